// ===== hdl/jac_pkg.sv =====
// Shared constants, types and codes for the joystick axis conditioner.
package jac_pkg;

  // Sample and axis geometry
  localparam int SAMPLE_BITS = 12;
  localparam int AXIS_COUNT  = 4;
  localparam int AX_W        = $clog2(AXIS_COUNT);
  localparam logic [SAMPLE_BITS-1:0] RAW_MAX = {SAMPLE_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] RAW_MID = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));

  // Averaging: sum width covers up to 32 samples
  localparam int AVG_SAMPLES_DEF = 20;
  localparam int AVG_MAX         = 32;
  localparam int SUM_W           = SAMPLE_BITS + $clog2(AVG_MAX);

  // Register and field widths
  localparam int DZ_W   = 11;
  localparam int HOLD_W = 16;
  localparam int OM_W   = 7;
  localparam int MS_W   = 10;
  localparam int AXIS_W = 8;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  // Divider dividend: offset magnitude times full scale
  localparam int PROD_W = SAMPLE_BITS + OM_W;

  // Register reset values
  localparam logic [DZ_W-1:0]   DEAD_ZONE_RST = DZ_W'(120);
  localparam logic [HOLD_W-1:0] HOLD_TIME_RST = HOLD_W'(3000);
  localparam logic [OM_W-1:0]   OUT_MAX_RST   = OM_W'(100);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX   = CFG_IDX_W'(2);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [AXIS_COUNT-1:0][SAMPLE_BITS-1:0] sample_arr_t;
  typedef logic [AXIS_COUNT-1:0][SUM_W-1:0]       sum_arr_t;
  typedef logic [AXIS_COUNT-1:0][AXIS_W-1:0]      axis_arr_t;

  // One classified request from front to back
  typedef struct packed {
    sample_arr_t raw;
    sum_arr_t    sum;
    logic        calibrating;
    logic        done;
  } jac_job_t;

  // One finished result
  typedef struct packed {
    axis_arr_t axis;
    logic      calibrating;
    logic      done;
  } jac_res_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RECENTRE,
    BK_SC_START,
    BK_SC_WAIT,
    BK_HOLD
  } back_state_e;

endpackage

// ===== hdl/jac_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module jac_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [jac_pkg::PROD_W-1:0]       dividend_i,
  input  logic [jac_pkg::SAMPLE_BITS-1:0]  divisor_i,
  output logic                             done_o,
  output logic [jac_pkg::PROD_W-1:0]       quotient_o
);

  localparam int DW  = jac_pkg::PROD_W;
  localparam int VW  = jac_pkg::SAMPLE_BITS;
  localparam int CW  = $clog2(DW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q;
  logic [VW:0]   shifted;
  logic [VW+1:0] diff;
  logic          ge;

  // One restoring step
  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    ge      = ~diff[VW+1];
    rem_d   = ge ? diff[VW-1:0] : shifted[VW-1:0];
    quo_d   = {quo_q[DW-2:0], ge};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // A new division never starts over a running one
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

endmodule

// ===== hdl/jac_fifo.sv =====
// Two-entry request queue between the front and back parts.
module jac_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  jac_pkg::jac_job_t  push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output jac_pkg::jac_job_t  pop_data_o
);

  localparam int DEPTH = jac_pkg::QUEUE_DEPTH;
  localparam int PW    = jac_pkg::QPTR_W;
  localparam int CW    = jac_pkg::QCNT_W;

  jac_pkg::jac_job_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CW'(1);
        2'b01:   count_q <= count_q - CW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o     = (count_q == CW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // The back never takes from an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue popped while empty");

endmodule

// ===== hdl/jac_front.sv =====
// Front part: accepts items, tracks the button hold and accumulates averaging sums.
module jac_front #(
  parameter int AVG_SAMPLES = jac_pkg::AVG_SAMPLES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  jac_pkg::sample_arr_t          raw_i,
  input  logic                          both_held_i,
  input  logic [jac_pkg::MS_W-1:0]      elapsed_ms_i,
  input  logic [jac_pkg::HOLD_W-1:0]    hold_time_i,
  input  logic                          full_i,
  output logic                          push_o,
  output jac_pkg::jac_job_t             job_o
);

  localparam int HW  = jac_pkg::HOLD_W;
  localparam int CNW = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;

  logic             accept;
  logic             averaging_q, averaging_d;
  logic             hold_active_q, hold_active_d;
  logic [HW-1:0]    hold_el_q, hold_el_d;
  logic [CNW-1:0]   count_q, count_d;
  jac_pkg::sum_arr_t sum_q, sum_d, sum_inc;
  logic [HW:0]      el_sum;
  logic             cal, done;

  assign accept     = in_valid_i && !full_i;
  assign in_stall_o = full_i;
  assign push_o     = accept;

  // Hold timer and averaging control
  always_comb begin
    averaging_d   = averaging_q;
    hold_active_d = hold_active_q;
    hold_el_d     = hold_el_q;
    count_d       = count_q;
    sum_d         = sum_q;
    cal           = 1'b0;
    done          = 1'b0;
    el_sum        = {1'b0, hold_el_q} + (HW + 1)'(elapsed_ms_i);
    for (int i = 0; i < jac_pkg::AXIS_COUNT; i++) begin
      sum_inc[i] = sum_q[i] + jac_pkg::SUM_W'(raw_i[i]);
    end

    if (averaging_q) begin
      cal     = 1'b1;
      sum_d   = sum_inc;
      count_d = count_q + CNW'(1);
      if (count_q == CNW'(AVG_SAMPLES - 1)) begin
        done          = 1'b1;
        sum_d         = '0;
        count_d       = '0;
        averaging_d   = 1'b0;
        hold_active_d = 1'b0;
        hold_el_d     = '0;
      end
    end else if (!both_held_i) begin
      hold_active_d = 1'b0;
      hold_el_d     = '0;
    end else begin
      cal = 1'b1;
      if (!hold_active_q) begin
        hold_active_d = 1'b1;
        hold_el_d     = '0;
      end else begin
        hold_el_d = el_sum[HW] ? {HW{1'b1}} : el_sum[HW-1:0];
      end
      if (hold_el_d >= hold_time_i) begin
        averaging_d = 1'b1;
        count_d     = '0;
        sum_d       = '0;
      end
    end
  end

  // Request to the back part
  always_comb begin
    job_o.raw         = raw_i;
    job_o.sum         = sum_inc;
    job_o.calibrating = cal;
    job_o.done        = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      averaging_q   <= 1'b0;
      hold_active_q <= 1'b0;
      hold_el_q     <= '0;
      count_q       <= '0;
      sum_q         <= '0;
    end else if (accept) begin
      averaging_q   <= averaging_d;
      hold_active_q <= hold_active_d;
      hold_el_q     <= hold_el_d;
      count_q       <= count_d;
      sum_q         <= sum_d;
    end
  end

  // Averaging only ever follows a hold that was running
  a_avg_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    averaging_q |-> hold_active_q)
    else $error("averaging without an active hold");

endmodule

// ===== hdl/jac_back.sv =====
// Back part: recomputes centres, scales each axis through the shared divider.
module jac_back #(
  parameter int AVG_SAMPLES = jac_pkg::AVG_SAMPLES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  jac_pkg::jac_job_t             job_i,
  output logic                          pop_o,
  input  logic [jac_pkg::DZ_W-1:0]      dead_zone_i,
  input  logic [jac_pkg::OM_W-1:0]      out_max_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output jac_pkg::jac_res_t             res_o
);

  localparam int SB = jac_pkg::SAMPLE_BITS;
  localparam int AW = jac_pkg::AX_W;
  localparam int PW = jac_pkg::PROD_W;
  localparam int OW = jac_pkg::OM_W;
  localparam int XW = jac_pkg::AXIS_W;
  localparam logic [AW-1:0] AX_LAST = AW'(jac_pkg::AXIS_COUNT - 1);

  // Average by reciprocal multiply: exact floor for every SW-bit sum
  localparam int SW = jac_pkg::SUM_W;
  localparam int RL = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 0;
  localparam int RS = SW + RL;
  localparam int RW = SW + 1;
  localparam int MW = SW + RW;
  localparam logic [RW-1:0] RECIP = RW'(((1 << RS) + AVG_SAMPLES - 1) / AVG_SAMPLES);

  jac_pkg::back_state_e state_q, state_d;
  logic [AW-1:0]        ax_q;
  jac_pkg::jac_job_t    job_q;
  logic [SB-1:0]        center_q [jac_pkg::AXIS_COUNT];
  jac_pkg::axis_arr_t   axis_q;
  logic                 neg_q;
  jac_pkg::jac_res_t    out_q;
  logic                 out_valid_q;

  logic                 div_start;
  logic [PW-1:0]        div_dividend;
  logic [SB-1:0]        div_divisor;
  logic                 div_done;
  logic [PW-1:0]        div_quo;
  logic                 load_out;
  logic [MW-1:0]        avg_prod;
  logic [SB-1:0]        avg_ctr;

  // Scaling set-up for the current axis
  logic [SB-1:0]   ctr, raw, mag, span, up_span;
  logic [SB:0]     diff;
  logic            neg, in_dz;
  logic [PW-1:0]   num;
  logic [OW-1:0]   q_clamp;
  logic [XW-1:0]   axis_val;

  always_comb begin
    ctr     = center_q[ax_q];
    raw     = job_q.raw[ax_q];
    diff    = {1'b0, raw} - {1'b0, ctr};
    neg     = diff[SB];
    mag     = neg ? SB'(-diff) : diff[SB-1:0];
    in_dz   = (mag < SB'(dead_zone_i));
    up_span = jac_pkg::RAW_MAX - ctr;
    if (neg) begin
      span = (ctr != '0) ? ctr : SB'(1);
    end else begin
      span = (up_span != '0) ? up_span : SB'(1);
    end
    num = in_dz ? '0 : PW'(mag) * PW'(out_max_i);
  end

  // New centre for the current axis: sum over the sample count
  always_comb begin
    avg_prod = MW'(job_q.sum[ax_q]) * MW'(RECIP);
    avg_ctr  = avg_prod[RS +: SB];
  end

  // Clamp and sign the quotient
  always_comb begin
    q_clamp  = (div_quo > PW'(out_max_i)) ? out_max_i : div_quo[OW-1:0];
    axis_val = neg_q ? XW'(-{1'b0, q_clamp}) : XW'({1'b0, q_clamp});
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jac_pkg::BK_IDLE: begin
        if (job_valid_i) begin
          state_d = job_i.done ? jac_pkg::BK_RECENTRE : jac_pkg::BK_SC_START;
        end
      end
      jac_pkg::BK_RECENTRE: begin
        if (ax_q == AX_LAST) begin
          state_d = jac_pkg::BK_SC_START;
        end
      end
      jac_pkg::BK_SC_START: state_d = jac_pkg::BK_SC_WAIT;
      jac_pkg::BK_SC_WAIT: begin
        if (div_done) begin
          state_d = (ax_q == AX_LAST) ? jac_pkg::BK_HOLD : jac_pkg::BK_SC_START;
        end
      end
      jac_pkg::BK_HOLD: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = jac_pkg::BK_IDLE;
        end
      end
      default: state_d = jac_pkg::BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop_o        = 1'b0;
    div_start    = 1'b0;
    div_dividend = num;
    div_divisor  = span;
    load_out     = 1'b0;
    unique case (state_q)
      jac_pkg::BK_IDLE:      pop_o = job_valid_i;
      jac_pkg::BK_SC_START:  div_start = 1'b1;
      jac_pkg::BK_HOLD:      load_out = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  jac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Control state, centres and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jac_pkg::BK_IDLE;
      ax_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < jac_pkg::AXIS_COUNT; i++) begin
        center_q[i] <= jac_pkg::RAW_MID;
      end
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        ax_q <= '0;
      end else if (div_done || state_q == jac_pkg::BK_RECENTRE) begin
        ax_q <= (ax_q == AX_LAST) ? '0 : ax_q + AW'(1);
      end
      if (state_q == jac_pkg::BK_RECENTRE) begin
        center_q[ax_q] <= avg_ctr;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (state_q == jac_pkg::BK_SC_START) begin
      neg_q <= neg && !in_dz;
    end
    if (state_q == jac_pkg::BK_SC_WAIT && div_done) begin
      axis_q[ax_q] <= axis_val;
    end
    if (load_out) begin
      out_q.axis        <= axis_q;
      out_q.calibrating <= job_q.calibrating;
      out_q.done        <= job_q.done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  // Divider results arrive only while the wait state expects them
  a_div_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == jac_pkg::BK_SC_WAIT))
    else $error("unexpected divider result");

  // A recentre result is always flagged as calibrating
  a_done_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done) |-> out_q.calibrating)
    else $error("recentre result without calibrating flag");

endmodule

// ===== hdl/joystick_axis_conditioner.sv =====
// Joystick axis conditioner top level: configuration registers and front/queue/back.
//
// Each request carries four raw 12-bit stick samples, a both-buttons flag and
// the milliseconds since the previous request; each yields one result with four
// signed axis values (dead zone, centre offset, scaled to +-out_max), a
// calibrating flag and a recentre-done flag. The front takes a request into a
// two-entry queue while that queue is not full; the back then scales the four axes,
// one pass each through a shared bit-serial divider, and on a request that completes
// a recentre first sets the four new centres, each taken from its sample sum by a
// reciprocal multiply. Results wait in an output register, so the back goes on
// with further requests meanwhile. Configuration must be written by the user through
// cfg_we_i/cfg_idx_i/cfg_wdata_i only while idle; the block does not enforce this.
module joystick_axis_conditioner #(
  parameter int AVG_SAMPLES = jac_pkg::AVG_SAMPLES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [jac_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [jac_pkg::CFG_W-1:0]         cfg_wdata_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [jac_pkg::SAMPLE_BITS-1:0]   raw_x0_i,
  input  logic [jac_pkg::SAMPLE_BITS-1:0]   raw_y0_i,
  input  logic [jac_pkg::SAMPLE_BITS-1:0]   raw_x1_i,
  input  logic [jac_pkg::SAMPLE_BITS-1:0]   raw_y1_i,
  input  logic                              both_held_i,
  input  logic [jac_pkg::MS_W-1:0]          elapsed_ms_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [jac_pkg::AXIS_W-1:0] axis_x0_o,
  output logic signed [jac_pkg::AXIS_W-1:0] axis_y0_o,
  output logic signed [jac_pkg::AXIS_W-1:0] axis_x1_o,
  output logic signed [jac_pkg::AXIS_W-1:0] axis_y1_o,
  output logic                              calibrating_o,
  output logic                              recenter_done_o
);

  logic [jac_pkg::DZ_W-1:0]   dead_zone_q;
  logic [jac_pkg::HOLD_W-1:0] hold_time_q;
  logic [jac_pkg::OM_W-1:0]   out_max_q;

  jac_pkg::sample_arr_t raw;
  jac_pkg::jac_job_t    push_job, pop_job;
  jac_pkg::jac_res_t    res;
  logic                 q_full, q_valid, push, pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q <= jac_pkg::DEAD_ZONE_RST;
      hold_time_q <= jac_pkg::HOLD_TIME_RST;
      out_max_q   <= jac_pkg::OUT_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jac_pkg::CFG_DEAD_ZONE: dead_zone_q <= cfg_wdata_i[jac_pkg::DZ_W-1:0];
        jac_pkg::CFG_HOLD_TIME: hold_time_q <= cfg_wdata_i[jac_pkg::HOLD_W-1:0];
        jac_pkg::CFG_OUT_MAX:   out_max_q   <= cfg_wdata_i[jac_pkg::OM_W-1:0];
        default: ;
      endcase
    end
  end

  // Gather the sample ports
  assign raw[0] = raw_x0_i;
  assign raw[1] = raw_y0_i;
  assign raw[2] = raw_x1_i;
  assign raw[3] = raw_y1_i;

  jac_front #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .raw_i        (raw),
    .both_held_i  (both_held_i),
    .elapsed_ms_i (elapsed_ms_i),
    .hold_time_i  (hold_time_q),
    .full_i       (q_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  jac_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_job)
  );

  jac_back #(
    .AVG_SAMPLES (AVG_SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .dead_zone_i (dead_zone_q),
    .out_max_i   (out_max_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  // Result fields
  assign axis_x0_o       = res.axis[0];
  assign axis_y0_o       = res.axis[1];
  assign axis_x1_o       = res.axis[2];
  assign axis_y1_o       = res.axis[3];
  assign calibrating_o   = res.calibrating;
  assign recenter_done_o = res.done;

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the joystick axis conditioner: predicts every result and compares.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One request as offered on the input channel
  typedef struct packed {
    jac_pkg::sample_arr_t         raw;
    logic                         both_held;
    logic [jac_pkg::MS_W-1:0]     elapsed_ms;
  } stick_req_t;

  // Tracks centres, hold timer and averaging, and holds the results still owed
  class stick_checker;
    logic [jac_pkg::DZ_W-1:0]        dead_zone;
    logic [jac_pkg::HOLD_W-1:0]      hold_time;
    logic [jac_pkg::OM_W-1:0]        out_max;
    logic [jac_pkg::SAMPLE_BITS-1:0] center [jac_pkg::AXIS_COUNT];
    int unsigned                     sums [jac_pkg::AXIS_COUNT];
    int unsigned                     hold_ms;
    int unsigned                     avg_count;
    bit                              holding;
    bit                              averaging;
    jac_pkg::jac_res_t               owed_results[$];
    int unsigned                     mismatches;

    function new();
      dead_zone = jac_pkg::DEAD_ZONE_RST;
      hold_time = jac_pkg::HOLD_TIME_RST;
      out_max   = jac_pkg::OUT_MAX_RST;
      for (int i = 0; i < jac_pkg::AXIS_COUNT; i++) begin
        center[i] = jac_pkg::RAW_MID;
        sums[i]   = 0;
      end
      hold_ms    = 0;
      avg_count  = 0;
      holding    = 1'b0;
      averaging  = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [jac_pkg::CFG_IDX_W-1:0] idx,
                          logic [jac_pkg::CFG_W-1:0] value);
      case (idx)
        jac_pkg::CFG_DEAD_ZONE: dead_zone = value[jac_pkg::DZ_W-1:0];
        jac_pkg::CFG_HOLD_TIME: hold_time = value[jac_pkg::HOLD_W-1:0];
        jac_pkg::CFG_OUT_MAX:   out_max   = value[jac_pkg::OM_W-1:0];
        default: ;
      endcase
    endfunction

    // Dead zone, one-sided span, truncating divide, clamp to +-out_max
    function logic [jac_pkg::AXIS_W-1:0] scale_offset(logic [jac_pkg::SAMPLE_BITS-1:0] raw,
                                                      logic [jac_pkg::SAMPLE_BITS-1:0] ctr);
      int offs;
      int span;
      int m;
      offs = int'(raw) - int'(ctr);
      if ((offs < 0 ? -offs : offs) < int'(dead_zone)) offs = 0;
      if (offs < 0) span = (ctr != 0) ? int'(ctr) : 1;
      else span = (int'(jac_pkg::RAW_MAX) - int'(ctr) > 0) ?
                  int'(jac_pkg::RAW_MAX) - int'(ctr) : 1;
      m = (offs * int'(out_max)) / span;
      if (m > int'(out_max)) m = int'(out_max);
      if (m < -int'(out_max)) m = -int'(out_max);
      return m[jac_pkg::AXIS_W-1:0];
    endfunction

    // Advance the calibration state for one accepted request and queue its result
    function void note_request(stick_req_t req);
      jac_pkg::jac_res_t res;
      res = '0;
      if (averaging) begin
        res.calibrating = 1'b1;
        for (int i = 0; i < jac_pkg::AXIS_COUNT; i++) sums[i] += req.raw[i];
        avg_count++;
        if (avg_count >= jac_pkg::AVG_SAMPLES_DEF) begin
          for (int i = 0; i < jac_pkg::AXIS_COUNT; i++) begin
            center[i] = jac_pkg::SAMPLE_BITS'(sums[i] / jac_pkg::AVG_SAMPLES_DEF);
            sums[i]   = 0;
          end
          avg_count = 0;
          averaging = 1'b0;
          holding   = 1'b0;
          hold_ms   = 0;
          res.done  = 1'b1;
        end
      end else if (!req.both_held) begin
        holding = 1'b0;
        hold_ms = 0;
      end else begin
        res.calibrating = 1'b1;
        // first held request only starts the timer
        if (!holding) begin
          holding = 1'b1;
          hold_ms = 0;
        end else begin
          hold_ms += req.elapsed_ms;
          if (hold_ms > 65535) hold_ms = 65535;
        end
        if (hold_ms >= hold_time) begin
          averaging = 1'b1;
          avg_count = 0;
          for (int i = 0; i < jac_pkg::AXIS_COUNT; i++) sums[i] = 0;
        end
      end
      // new centres already apply to this request
      for (int i = 0; i < jac_pkg::AXIS_COUNT; i++)
        res.axis[i] = scale_offset(req.raw[i], center[i]);
      owed_results.push_back(res);
    endfunction

    function string fmt_res(jac_pkg::jac_res_t r);
      return $sformatf("x0=%0d y0=%0d x1=%0d y1=%0d cal=%0b done=%0b",
                       $signed(r.axis[0]), $signed(r.axis[1]), $signed(r.axis[2]),
                       $signed(r.axis[3]), r.calibrating, r.done);
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
    endfunction

    function void check_result(jac_pkg::jac_res_t got);
      jac_pkg::jac_res_t want;
      bit                bad;
      if (owed_results.size() == 0) begin
        report({"result with nothing outstanding: ", fmt_res(got)});
        return;
      end
      want = owed_results.pop_front();
      bad  = (got.calibrating !== want.calibrating) || (got.done !== want.done);
      for (int i = 0; i < jac_pkg::AXIS_COUNT; i++) bad |= (got.axis[i] !== want.axis[i]);
      if (bad) report({"expected ", fmt_res(want), " got ", fmt_res(got)});
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction
  endclass

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 cfg_we_i = 1'b0;
  logic [jac_pkg::CFG_IDX_W-1:0]        cfg_idx_i = jac_pkg::CFG_DEAD_ZONE;
  logic [jac_pkg::CFG_W-1:0]            cfg_wdata_i = '0;
  logic                                 in_valid_i = 1'b0;
  logic                                 in_stall_o;
  logic [jac_pkg::SAMPLE_BITS-1:0]      raw_x0_i = '0;
  logic [jac_pkg::SAMPLE_BITS-1:0]      raw_y0_i = '0;
  logic [jac_pkg::SAMPLE_BITS-1:0]      raw_x1_i = '0;
  logic [jac_pkg::SAMPLE_BITS-1:0]      raw_y1_i = '0;
  logic                                 both_held_i = 1'b0;
  logic [jac_pkg::MS_W-1:0]             elapsed_ms_i = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic signed [jac_pkg::AXIS_W-1:0]    axis_x0_o;
  logic signed [jac_pkg::AXIS_W-1:0]    axis_y0_o;
  logic signed [jac_pkg::AXIS_W-1:0]    axis_x1_o;
  logic signed [jac_pkg::AXIS_W-1:0]    axis_y1_o;
  logic                                 calibrating_o;
  logic                                 recenter_done_o;

  stick_checker sb = new();
  int unsigned  req_total = 0;

  joystick_axis_conditioner u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .raw_x0_i       (raw_x0_i),
    .raw_y0_i       (raw_y0_i),
    .raw_x1_i       (raw_x1_i),
    .raw_y1_i       (raw_y1_i),
    .both_held_i    (both_held_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .axis_x0_o      (axis_x0_o),
    .axis_y0_o      (axis_y0_o),
    .axis_x1_o      (axis_x1_o),
    .axis_y1_o      (axis_y1_o),
    .calibrating_o  (calibrating_o),
    .recenter_done_o(recenter_done_o)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog
  initial begin : watchdog
    #(60_000_000);
    $display("status: fail");
    $finish;
  end

  function automatic logic [jac_pkg::SAMPLE_BITS-1:0] clamp_raw(int v);
    if (v < 0) v = 0;
    if (v > int'(jac_pkg::RAW_MAX)) v = int'(jac_pkg::RAW_MAX);
    return jac_pkg::SAMPLE_BITS'(v);
  endfunction

  function automatic jac_pkg::sample_arr_t mk_raw(int x0, int y0, int x1, int y1);
    jac_pkg::sample_arr_t r;
    r[0] = jac_pkg::SAMPLE_BITS'(x0);
    r[1] = jac_pkg::SAMPLE_BITS'(y0);
    r[2] = jac_pkg::SAMPLE_BITS'(x1);
    r[3] = jac_pkg::SAMPLE_BITS'(y1);
    return r;
  endfunction

  // Raw value biased towards the centre and the dead-zone edges of this axis
  function automatic logic [jac_pkg::SAMPLE_BITS-1:0] pick_raw(int ax);
    int          c;
    int          dz;
    int unsigned k;
    int          v;
    c  = int'(sb.center[ax]);
    dz = int'(sb.dead_zone);
    k  = $urandom_range(0, 9);
    if (k < 4) v = int'($urandom_range(0, 4095));
    else if (k < 6) v = c + int'($urandom_range(0, 2 * dz + 6)) - (dz + 3);
    else if (k < 8) v = c + ($urandom_range(0, 1) ? 1 : -1) * (dz - int'($urandom_range(0, 1)));
    else if (k == 8) v = $urandom_range(0, 1) ? 0 : int'(jac_pkg::RAW_MAX);
    else v = c;
    return clamp_raw(v);
  endfunction

  function automatic logic [jac_pkg::SAMPLE_BITS-1:0] jitter(
      logic [jac_pkg::SAMPLE_BITS-1:0] mid, int spread);
    return clamp_raw(int'(mid) + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // Sender gaps: mostly none or short, a few long, with windows of no gaps
  function automatic int unsigned pick_gap();
    int unsigned r;
    if ((req_total / 40) % 5 == 4) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request and hold it until taken
  task automatic send_request(input stick_req_t req);
    int unsigned gap;
    raw_x0_i     <= req.raw[0];
    raw_y0_i     <= req.raw[1];
    raw_x1_i     <= req.raw[2];
    raw_y1_i     <= req.raw[3];
    both_held_i  <= req.both_held;
    elapsed_ms_i <= req.elapsed_ms;
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_request(req);
    req_total++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_fields(input jac_pkg::sample_arr_t raw, input bit held,
                             input int unsigned ms);
    stick_req_t req;
    req.raw        = raw;
    req.both_held  = held;
    req.elapsed_ms = jac_pkg::MS_W'(ms);
    send_request(req);
  endtask

  task automatic noise_items(input int unsigned n);
    stick_req_t req;
    repeat (n) begin
      for (int i = 0; i < jac_pkg::AXIS_COUNT; i++) req.raw[i] = pick_raw(i);
      req.both_held  = 1'($urandom_range(0, 1));
      req.elapsed_ms = jac_pkg::MS_W'($urandom_range(0, 1023));
      send_request(req);
    end
  endtask

  // Hold both buttons until averaging starts, then feed samples around mid until done;
  // a broken run may let go once before the hold time is reached
  task automatic recenter_run(input jac_pkg::sample_arr_t mid, input int spread,
                              input bit broken);
    stick_req_t req;
    while (!sb.averaging) begin
      for (int i = 0; i < jac_pkg::AXIS_COUNT; i++) req.raw[i] = pick_raw(i);
      req.both_held  = 1'b1;
      req.elapsed_ms = ($urandom_range(0, 7) == 0) ? jac_pkg::MS_W'($urandom_range(0, 1023))
                                                   : jac_pkg::MS_W'($urandom_range(256, 1023));
      if (broken && $urandom_range(0, 3) == 0) begin
        req.both_held = 1'b0;
        broken        = 1'b0;
      end
      send_request(req);
    end
    while (sb.averaging) begin
      for (int i = 0; i < jac_pkg::AXIS_COUNT; i++) req.raw[i] = jitter(mid[i], spread);
      req.both_held  = ($urandom_range(0, 3) != 0);
      req.elapsed_ms = jac_pkg::MS_W'($urandom_range(0, 1023));
      send_request(req);
    end
  endtask

  // Wait until every owed result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [jac_pkg::CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= jac_pkg::CFG_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, jac_pkg::CFG_W'(value));
    @(posedge clk_i);
  endtask

  task automatic set_regs(input int unsigned dz, input int unsigned hold,
                          input int unsigned om);
    write_reg(jac_pkg::CFG_DEAD_ZONE, dz);
    write_reg(jac_pkg::CFG_HOLD_TIME, hold);
    write_reg(jac_pkg::CFG_OUT_MAX, om);
  endtask

  // Mixed phase: mostly full recentre runs with random content, the rest noise
  task automatic random_phase(input int unsigned n_items);
    int unsigned          start;
    int unsigned          k;
    jac_pkg::sample_arr_t mid;
    int                   spread;
    start = req_total;
    while (req_total - start < n_items) begin
      if ($urandom_range(0, 9) < 6) begin
        for (int i = 0; i < jac_pkg::AXIS_COUNT; i++) begin
          k = $urandom_range(0, 9);
          mid[i] = (k == 0) ? '0 : (k == 1) ? jac_pkg::RAW_MAX : (k == 2) ? jac_pkg::RAW_MID
                 : jac_pkg::SAMPLE_BITS'($urandom_range(0, 4095));
        end
        spread = $urandom_range(0, 1) ? int'($urandom_range(0, 16)) : int'($urandom_range(0, 400));
        recenter_run(mid, spread, $urandom_range(0, 3) == 0);
      end else begin
        noise_items($urandom_range(3, 12));
      end
    end
    drain();
  endtask

  // Result side: check every accepted result, stall at random, one long hold-off
  initial begin : result_sink
    int unsigned       stall_left;
    int unsigned       results_seen;
    int unsigned       cycle_cnt;
    int unsigned       r;
    bit                held_off;
    jac_pkg::jac_res_t got;
    stall_left   = 0;
    results_seen = 0;
    cycle_cnt    = 0;
    held_off     = 1'b0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        got.axis[0]     = axis_x0_o;
        got.axis[1]     = axis_y0_o;
        got.axis[2]     = axis_x1_o;
        got.axis[3]     = axis_y1_o;
        got.calibrating = calibrating_o;
        got.done        = recenter_done_o;
        sb.check_result(got);
        results_seen++;
      end
      if (!held_off && results_seen >= 150) begin
        held_off   = 1'b1;
        stall_left = 2500;
      end else if (stall_left == 0 && (cycle_cnt / 400) % 4 != 3) begin
        r = $urandom_range(0, 99);
        if (r < 60) stall_left = 0;
        else if (r < 92) stall_left = $urandom_range(1, 3);
        else if (r < 98) stall_left = $urandom_range(4, 15);
        else stall_left = $urandom_range(30, 80);
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: field extremes and dead-zone edges
    send_fields(mk_raw(0, 0, 0, 0), 1'b0, 0);
    send_fields(mk_raw(4095, 4095, 4095, 4095), 1'b0, 1023);
    send_fields(mk_raw(2048, 2048, 2048, 2048), 1'b0, 0);
    send_fields(mk_raw(2048 + 119, 2048 - 119, 2048 + 120, 2048 - 120), 1'b0, 0);
    send_fields(mk_raw(2049, 2047, 1, 4094), 1'b0, 0);
    send_fields(mk_raw('hAAA, 'h555, 'h555, 'hAAA), 1'b0, 'h2AA);
    send_fields(mk_raw('h555, 'hAAA, 'hAAA, 'h555), 1'b0, 'h155);

    // Release before the hold time: timer clears
    send_fields(mk_raw(2048, 2048, 2048, 2048), 1'b1, 1023);
    send_fields(mk_raw(2048, 2048, 2048, 2048), 1'b1, 1023);
    send_fields(mk_raw(2048, 2048, 2048, 2048), 1'b1, 1023);
    send_fields(mk_raw(2048, 2048, 2048, 2048), 1'b0, 1023);

    // Full hold: start request not timed, trigger on the fourth, release ignored mid-average
    send_fields(mk_raw(2048, 2048, 2048, 2048), 1'b1, 500);
    repeat (3) send_fields(mk_raw(2048, 2048, 2048, 2048), 1'b1, 1023);
    for (int i = 0; i < jac_pkg::AVG_SAMPLES_DEF; i++)
      send_fields(mk_raw(1000, 3000, (i % 2) ? 4095 : 0, 2050 + i), (i % 3) != 0, 1023);
    // still held after completion: a fresh hold starts
    send_fields(mk_raw(1000, 3000, 2047, 2059), 1'b1, 1023);
    send_fields(mk_raw(0, 4095, 2047, 2100), 1'b0, 0);
    drain();

    // Zero hold time, no dead zone, full scale; centres driven to both rails
    set_regs(0, 0, 127);
    recenter_run(mk_raw(0, 0, 0, 0), 0, 1'b0);
    send_fields(mk_raw(0, 4095, 1, 2048), 1'b0, 0);
    recenter_run(mk_raw(4095, 4095, 4095, 4095), 0, 1'b0);
    send_fields(mk_raw(4095, 0, 4094, 2048), 1'b0, 0);
    drain();

    // Zero output scale, widest dead zone, shortest non-zero hold
    set_regs(2047, 1, 0);
    noise_items(8);
    recenter_run(mk_raw(2048, 2048, 2048, 2048), 30, 1'b0);
    drain();

    // Random phases over extreme and random settings
    set_regs(0, 1, 1);
    random_phase(100);
    set_regs(2047, 65535, 127);
    random_phase(100);
    repeat (3) begin
      set_regs(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 300),
               $urandom_range(1, 5000), $urandom_range(1, 127));
      random_phase(100);
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
